// File: rtl/core/tfd_pkg.sv
package tfd_pkg;

  localparam int unsigned BodyBytes = 15;
  localparam int unsigned IdW       = 7;
  localparam int unsigned SlotW     = 4;
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QPtrW     = 1;
  localparam int unsigned QCntW     = 2;

  // frame positions
  localparam logic [SlotW-1:0] AuxPos    = 4'd15;
  localparam logic [SlotW-1:0] SyncPos   = 4'd3;
  localparam logic [SlotW-1:0] LastBody  = 4'd14;
  localparam logic [SlotW-1:0] FlushSlot = 4'd15;

  localparam logic [7:0] SyncFill = 8'hFF;
  localparam logic [7:0] SyncTail = 8'h7F;

  localparam logic [IdW-1:0] SourceIdReset = 7'd1;

  // configuration register indexes
  localparam logic RegTraceSourceId = 1'b0;

  typedef logic [BodyBytes-1:0][7:0] frame_body_t;

  typedef struct packed {
    frame_body_t body;
    logic [7:0]  aux;
    logic        frame_v;  // a complete frame is carried
    logic        eot;      // end of capture after this entry
  } frame_entry_t;

endpackage

// File: rtl/core/tfd_front.sv
module tfd_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            in_byte_i,
  input  logic                  end_of_trace_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output tfd_pkg::frame_entry_t push_entry_o
);

  logic [tfd_pkg::SlotW-1:0] pos_q, pos_d;
  logic                      sync_q, sync_d;
  tfd_pkg::frame_body_t      store_q;
  logic                      accept;
  logic                      is_aux;
  logic                      is_sync;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_aux     = (pos_q == tfd_pkg::AuxPos);
  assign is_sync    = (pos_q == tfd_pkg::SyncPos) && !sync_q &&
                      (store_q[0] == tfd_pkg::SyncFill) &&
                      (store_q[1] == tfd_pkg::SyncFill) &&
                      (store_q[2] == tfd_pkg::SyncFill) &&
                      (in_byte_i == tfd_pkg::SyncTail);

  assign push_o               = accept && (is_aux || end_of_trace_i);
  assign push_entry_o.body    = store_q;
  assign push_entry_o.aux     = in_byte_i;
  assign push_entry_o.frame_v = is_aux;
  assign push_entry_o.eot     = end_of_trace_i;

  always_comb begin
    pos_d  = pos_q;
    sync_d = sync_q;
    if (accept) begin
      priority if (is_aux) begin
        pos_d  = '0;
        sync_d = 1'b0;
      end else if (is_sync) begin
        // drop one separator at this boundary
        pos_d  = '0;
        sync_d = 1'b1;
      end else begin
        pos_d = pos_q + 1'b1;
      end
      if (end_of_trace_i) begin
        pos_d  = '0;
        sync_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      sync_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      sync_q <= sync_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !is_aux && !is_sync) begin
      store_q[pos_q] <= in_byte_i;
    end
  end

endmodule

// File: rtl/core/tfd_queue.sv
module tfd_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  tfd_pkg::frame_entry_t push_entry_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output tfd_pkg::frame_entry_t head_o
);

  tfd_pkg::frame_entry_t     mem_q [tfd_pkg::QDepth];
  logic [tfd_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [tfd_pkg::QCntW-1:0] cnt_q;
  logic                      do_pop;

  assign full_o  = (cnt_q == tfd_pkg::QCntW'(tfd_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({push_i, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// File: rtl/core/tfd_back.sv
module tfd_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [tfd_pkg::IdW-1:0]  trace_source_id_i,
  input  logic                     q_empty_i,
  input  tfd_pkg::frame_entry_t    head_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [7:0]               out_byte_o,
  output logic                     last_of_frame_o
);

  logic [tfd_pkg::SlotW-1:0] slot_q, slot_d;
  logic [tfd_pkg::IdW-1:0]   cur_q, cur_d;
  logic                      defer_v_q, defer_v_d;
  logic [tfd_pkg::IdW-1:0]   defer_id_q, defer_id_d;
  logic                      hold_v_q, hold_v_d;
  logic [7:0]                hold_q, hold_d;
  logic                      out_v_q, out_v_d;
  logic [7:0]                out_q, out_d;
  logic                      last_q, last_d;

  logic       active;
  logic       flush;
  logic       emit;
  logic [7:0] emit_val;
  logic [7:0] cur_byte;
  logic       abit;
  logic       match;
  logic       move;
  logic       out_free;
  logic       step_ok;

  assign active   = !q_empty_i;
  assign flush    = active && (!head_i.frame_v || (slot_q == tfd_pkg::FlushSlot));
  assign cur_byte = (slot_q == tfd_pkg::FlushSlot) ? 8'h00 : head_i.body[slot_q];
  assign abit     = head_i.aux[slot_q[tfd_pkg::SlotW-1:1]];
  assign match    = (cur_q == trace_source_id_i);
  assign out_free = !out_v_q || !out_stall_i;

  // classify the current slot of the frame
  always_comb begin
    emit       = 1'b0;
    emit_val   = cur_byte;
    cur_d      = cur_q;
    defer_v_d  = defer_v_q;
    defer_id_d = defer_id_q;
    if (active && !flush) begin
      if (!slot_q[0]) begin
        if (cur_byte[0]) begin
          if ((slot_q == tfd_pkg::LastBody) || !abit) begin
            cur_d = cur_byte[7:1];
          end else begin
            // old id still owns the odd byte
            defer_v_d  = 1'b1;
            defer_id_d = cur_byte[7:1];
          end
        end else begin
          emit     = match;
          emit_val = {cur_byte[7:1], abit};
        end
      end else begin
        emit = match;
        if (defer_v_q) begin
          cur_d     = defer_id_q;
          defer_v_d = 1'b0;
        end
      end
    end
    if (flush && head_i.eot) begin
      cur_d = '0;
    end
  end

  assign move    = (emit || flush) && hold_v_q;
  assign step_ok = active && (!move || out_free);
  assign pop_o   = step_ok && flush;

  always_comb begin
    slot_d   = slot_q;
    hold_v_d = hold_v_q;
    hold_d   = hold_q;
    out_v_d  = out_v_q && out_stall_i;
    out_d    = out_q;
    last_d   = last_q;
    if (step_ok) begin
      slot_d = flush ? '0 : slot_q + 1'b1;
      if (move) begin
        out_v_d = 1'b1;
        out_d   = hold_q;
        last_d  = flush;
      end
      if (emit) begin
        hold_v_d = 1'b1;
        hold_d   = emit_val;
      end else if (flush) begin
        hold_v_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= '0;
      cur_q     <= '0;
      defer_v_q <= 1'b0;
      hold_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      slot_q    <= slot_d;
      hold_v_q  <= hold_v_d;
      out_v_q   <= out_v_d;
      if (step_ok) begin
        cur_q     <= cur_d;
        defer_v_q <= defer_v_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_ok) begin
      defer_id_q <= defer_id_d;
    end
    hold_q <= hold_d;
    out_q  <= out_d;
    last_q <= last_d;
  end

  assign out_valid_o     = out_v_q;
  assign out_byte_o      = out_q;
  assign last_of_frame_o = last_q;

endmodule

// File: rtl/core/trace_frame_deformatter_unit.sv
// channel   direction  handshake                     payload
// in        sink       in_valid_i / in_stall_o       in_byte_i, end_of_trace_i
// out       source     out_valid_o / out_stall_i     out_byte_o, last_of_frame_o
// cfg       apb slave  psel, penable, pwrite, pready paddr, pwdata, prdata
//
// the front takes one byte per cycle; a frame completed by its aux byte, or an
// end of capture, goes into a two-entry queue (input stalls while it is full)
// the back walks a frame one frame byte per cycle plus one flush slot,
// and flushes an end-of-capture entry with no frame without walking it; output stalls hold it
// the last byte of a frame waits in a hold register until the frame is walked
// reset clears position, source id, queue and output valid; trace id resets to 1
module trace_frame_deformatter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_trace_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_of_frame_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [tfd_pkg::IdW-1:0] trace_source_id_q;
  logic                    cfg_wr;
  logic                    reg_sel;

  logic                  push;
  tfd_pkg::frame_entry_t push_entry;
  logic                  q_full;
  logic                  q_empty;
  logic                  pop;
  tfd_pkg::frame_entry_t head;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == tfd_pkg::RegTraceSourceId);
  assign cfg_wr  = psel && penable && pwrite && reg_sel;
  assign prdata  = reg_sel ? {25'd0, trace_source_id_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trace_source_id_q <= tfd_pkg::SourceIdReset;
    end else if (cfg_wr) begin
      trace_source_id_q <= pwdata[tfd_pkg::IdW-1:0];
    end
  end

  tfd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .end_of_trace_i (end_of_trace_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .push_entry_o   (push_entry)
  );

  tfd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .empty_o      (q_empty),
    .head_o       (head)
  );

  tfd_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .trace_source_id_i (trace_source_id_q),
    .q_empty_i         (q_empty),
    .head_i            (head),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_byte_o        (out_byte_o),
    .last_of_frame_o   (last_of_frame_o)
  );

endmodule
